// ===== hdl/pmgd_pkg.sv =====
package pmgd_pkg;

  localparam int FIELD_LANES     = 4;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int LANES_DEF       = 4;
  localparam int TICK_W_DEF      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_POLL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_POLL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LANE_ENABLE = 2'd2;

  localparam logic [CFG_DATA_W-1:0]  NORMAL_POLL_RST = 16'd30;
  localparam logic [CFG_DATA_W-1:0]  SEARCH_POLL_RST = 16'd5;
  localparam logic [FIELD_LANES-1:0] LANE_ENABLE_RST = 4'd1;

  typedef struct packed {
    logic near;
    logic taken;
  } lane_res_t;

endpackage

// ===== hdl/presence_miss_grace_detector.sv =====
// Presence detector with a miss hangover timer.
// Input channel (in_valid/in_ready, in_probe_present): one transaction per tick,
// one probe bit per lane. Each enabled lane polls its probe when due, at the
// normal period while near and at the search period otherwise; a miss while
// near holds the lane near until the search has lasted the normal period.
// Output channel (out_valid/out_ready): one transaction per input tick with the
// OR of all lanes, a change flag, and per-lane near and probe-taken masks.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// normal period, 1 search period, 2 lane enable mask; always ready. Write only
// while no tick is in flight.
// A result is registered and appears in the cycle after its tick is accepted.
// Throughput: one tick per cycle while the output is not stalled; all lanes
// update in parallel and the merge stage registers the result.
// Stall: the single output register holds its result while out_ready is low;
// in_ready stays high only if that register is free or being emptied.
// Reset (rst_n low, synchronous): lanes away, poll due at once, registers to
// their defaults (30, 5, lane 0 enabled), no result pending.
module presence_miss_grace_detector #(
  parameter int LANES  = pmgd_pkg::LANES_DEF,
  parameter int TICK_W = pmgd_pkg::TICK_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pmgd_pkg::FIELD_LANES-1:0] in_probe_present,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_person_near,
  output logic                             out_changed,
  output logic [pmgd_pkg::FIELD_LANES-1:0] out_lane_near_mask,
  output logic [pmgd_pkg::FIELD_LANES-1:0] out_probe_taken_mask,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pmgd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmgd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [pmgd_pkg::CFG_DATA_W-1:0]  normal_r;
  logic [pmgd_pkg::CFG_DATA_W-1:0]  search_r;
  logic [pmgd_pkg::FIELD_LANES-1:0] enable_r;
  logic                             fire;
  pmgd_pkg::lane_res_t [LANES-1:0]  lane_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign fire      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r <= pmgd_pkg::NORMAL_POLL_RST;
      search_r <= pmgd_pkg::SEARCH_POLL_RST;
      enable_r <= pmgd_pkg::LANE_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pmgd_pkg::REG_NORMAL_POLL: normal_r <= cfg_data;
        pmgd_pkg::REG_SEARCH_POLL: search_r <= cfg_data;
        pmgd_pkg::REG_LANE_ENABLE: enable_r <= cfg_data[pmgd_pkg::FIELD_LANES-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic en;
    logic hit;
    if (i < pmgd_pkg::FIELD_LANES) begin : g_field
      assign en  = enable_r[i];
      assign hit = in_probe_present[i];
    end else begin : g_extra
      assign en  = 1'b0;
      assign hit = 1'b0;
    end
    pmgd_lane #(.TICK_W(TICK_W)) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .fire         (fire),
      .en           (en),
      .hit          (hit),
      .normal_ticks (normal_r),
      .search_ticks (search_r),
      .res          (lane_res[i])
    );
  end

  pmgd_merge #(.LANES(LANES)) u_merge (
    .clk                  (clk),
    .rst_n                (rst_n),
    .fire                 (fire),
    .lane_res             (lane_res),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_person_near      (out_person_near),
    .out_changed          (out_changed),
    .out_lane_near_mask   (out_lane_near_mask),
    .out_probe_taken_mask (out_probe_taken_mask)
  );

endmodule

// ===== hdl/pmgd_lane.sv =====
module pmgd_lane #(
  parameter int TICK_W = pmgd_pkg::TICK_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  logic                            en,
  input  logic                            hit,
  input  logic [pmgd_pkg::CFG_DATA_W-1:0] normal_ticks,
  input  logic [pmgd_pkg::CFG_DATA_W-1:0] search_ticks,
  output pmgd_pkg::lane_res_t             res
);

  localparam int CMP_W = (TICK_W > pmgd_pkg::CFG_DATA_W) ? TICK_W : pmgd_pkg::CFG_DATA_W;

  logic              near_r, near_nxt;
  logic              srch_r, srch_nxt;
  logic [TICK_W-1:0] tsp_r, tsp_nxt;
  logic [TICK_W-1:0] age_r, age_nxt;
  logic [TICK_W-1:0] elapsed;
  logic [TICK_W-1:0] age_inc;
  logic [CMP_W-1:0]  period;
  logic              due;

  always_comb begin
    elapsed  = (tsp_r == {TICK_W{1'b1}}) ? tsp_r : tsp_r + TICK_W'(1);
    age_inc  = (age_r == {TICK_W{1'b1}}) ? age_r : age_r + TICK_W'(1);
    period   = (near_r && !srch_r) ? CMP_W'(normal_ticks) : CMP_W'(search_ticks);
    due      = CMP_W'(elapsed) >= period;
    near_nxt = near_r;
    srch_nxt = srch_r;
    tsp_nxt  = tsp_r;
    age_nxt  = srch_r ? age_inc : age_r;
    if (!en) begin
      near_nxt = 1'b0;
      srch_nxt = 1'b0;
      tsp_nxt  = {TICK_W{1'b1}};
      age_nxt  = '0;
      due      = 1'b0;
    end else if (!due) begin
      tsp_nxt = elapsed;
    end else begin
      tsp_nxt = '0;
      if (hit) begin
        near_nxt = 1'b1;
        srch_nxt = 1'b0;
        age_nxt  = '0;
      end else if (near_r) begin
        if (!srch_r) begin
          srch_nxt = 1'b1;
          age_nxt  = '0;
        end
        if (CMP_W'(age_nxt) >= CMP_W'(normal_ticks)) begin
          near_nxt = 1'b0;
          srch_nxt = 1'b0;
          age_nxt  = '0;
        end
      end
    end
    res.near  = near_nxt;
    res.taken = due;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= 1'b0;
      srch_r <= 1'b0;
      tsp_r  <= {TICK_W{1'b1}};
      age_r  <= '0;
    end else if (fire) begin
      near_r <= near_nxt;
      srch_r <= srch_nxt;
      tsp_r  <= tsp_nxt;
      age_r  <= age_nxt;
    end
  end

endmodule

// ===== hdl/pmgd_merge.sv =====
module pmgd_merge #(
  parameter int LANES = pmgd_pkg::LANES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  pmgd_pkg::lane_res_t [LANES-1:0]      lane_res,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_person_near,
  output logic                                 out_changed,
  output logic [pmgd_pkg::FIELD_LANES-1:0]     out_lane_near_mask,
  output logic [pmgd_pkg::FIELD_LANES-1:0]     out_probe_taken_mask
);

  logic                              valid_r, valid_nxt;
  logic                              last_r;
  logic                              any_near;
  logic [pmgd_pkg::FIELD_LANES-1:0]  near_mask;
  logic [pmgd_pkg::FIELD_LANES-1:0]  taken_mask;
  logic                              near_q_r, chg_q_r;
  logic [pmgd_pkg::FIELD_LANES-1:0]  near_mask_q_r, taken_mask_q_r;

  for (genvar i = 0; i < pmgd_pkg::FIELD_LANES; i++) begin : g_mask
    if (i < LANES) begin : g_on
      assign near_mask[i]  = lane_res[i].near;
      assign taken_mask[i] = lane_res[i].taken;
    end else begin : g_off
      assign near_mask[i]  = 1'b0;
      assign taken_mask[i] = 1'b0;
    end
  end

  always_comb begin
    any_near = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      any_near = any_near | lane_res[i].near;
    end
    valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (fire) begin
        last_r <= any_near;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      near_q_r       <= any_near;
      chg_q_r        <= any_near ^ last_r;
      near_mask_q_r  <= near_mask;
      taken_mask_q_r <= taken_mask;
    end
  end

  assign out_valid            = valid_r;
  assign out_person_near      = near_q_r;
  assign out_changed          = chg_q_r;
  assign out_lane_near_mask   = near_mask_q_r;
  assign out_probe_taken_mask = taken_mask_q_r;

endmodule
